@@ src/kerned_text_line_measure_defines.svh @@
// Assertion macros shared by the measurement block.
`ifndef KERNED_TEXT_LINE_MEASURE_DEFINES_SVH
`define KERNED_TEXT_LINE_MEASURE_DEFINES_SVH

// Same-cycle implication.
`define KTLM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ktlm: check failed");

// Next-cycle implication.
`define KTLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ktlm: check failed");

`endif

@@ src/ktlm_pkg.sv @@
package ktlm_pkg;

   localparam int GLYPH_CODES = 256;
   localparam int MAX_LINES   = 65536;
   localparam int GIDX_W      = $clog2(GLYPH_CODES);

   localparam int CODE_W   = 8;
   localparam int ADV_W    = 12;
   localparam int KERN_W   = 8;
   localparam int CFG_W    = 12;
   localparam int WIDTH_W  = 21;
   localparam int WIDEST_W = 20;
   localparam int INDEX_W  = 16;
   localparam int HEIGHT_W = 28;
   localparam int KIDX_W   = 2 * CODE_W;

   localparam logic [CODE_W-1:0]  NEWLINE_CODE = CODE_W'(10);
   localparam logic [INDEX_W-1:0] LINE_LAST    = INDEX_W'(MAX_LINES - 1);

   typedef enum logic [1:0] {
      ACT_GLYPH = 2'd0,
      ACT_KERN  = 2'd1,
      ACT_CHAR  = 2'd2,
      ACT_END   = 2'd3
   } ktlm_action_type;

   typedef enum logic [0:0] {
      CSR_LINE_HEIGHT = 1'b0,
      CSR_BASELINE    = 1'b1
   } ktlm_csr_type;

   // item handed from the table stage to the accumulate stage
   typedef struct packed {
      logic valid;
      logic is_end;
      logic is_newline;
      logic has_glyph;
      logic prev_had;
   } ktlm_stage_type;

   function automatic logic signed [WIDTH_W-1:0] sat_width(
      input logic signed [WIDTH_W+1:0] v);
      logic signed [WIDTH_W+1:0] hi;
      logic signed [WIDTH_W+1:0] lo;
      hi = (WIDTH_W+2)'((2 ** (WIDTH_W - 1)) - 1);
      lo = -hi - (WIDTH_W+2)'(1);
      if (v > hi) begin
         sat_width = hi[WIDTH_W-1:0];
      end else if (v < lo) begin
         sat_width = lo[WIDTH_W-1:0];
      end else begin
         sat_width = v[WIDTH_W-1:0];
      end
   endfunction

endpackage

@@ src/ktlm_channels.sv @@
interface ktlm_req_if import ktlm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   ktlm_action_type          action;
   logic [CODE_W-1:0]        char_code;
   logic [CODE_W-1:0]        second_code;
   logic                     glyph_present;
   logic [ADV_W-1:0]         advance;
   logic signed [KERN_W-1:0] kern_amount;

   modport source (output valid, action, char_code, second_code, glyph_present,
                   advance, kern_amount, input ready);
   modport sink (input valid, action, char_code, second_code, glyph_present,
                 advance, kern_amount, output ready);
endinterface

interface ktlm_rsp_if import ktlm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [WIDTH_W-1:0] line_width;
   logic [INDEX_W-1:0]        line_index;
   logic [WIDEST_W-1:0]       text_width;
   logic [HEIGHT_W-1:0]       text_height;
   logic                      is_final;

   modport source (output valid, line_width, line_index, text_width, text_height,
                   is_final, input ready);
   modport sink (input valid, line_width, line_index, text_width, text_height,
                 is_final, output ready);
endinterface

interface ktlm_csr_if import ktlm_pkg::*; ();
   logic             valid;
   logic             ready;
   ktlm_csr_type     index;
   logic [CFG_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/kerned_text_line_measure.sv @@
// Kerned text line measurement. Glyph writes, kerning writes, characters and
// end-of-text words all enter on req_ch at one word per clock while ready; each
// character reads the glyph advance memory and the 64K-entry kerning memory in
// the cycle it is taken and is summed into the running line width in the next, so
// the result of a newline or end word reaches rsp_ch through the stage and output
// registers. A result waiting in the output register stalls intake only when the
// next word also carries a result. After reset the kerning memory is zeroed one
// entry per cycle; req_ch is not ready during that sweep, csr_ch writes are.
module kerned_text_line_measure import ktlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ktlm_req_if.sink    req_ch,
   ktlm_rsp_if.source  rsp_ch,
   ktlm_csr_if.sink    csr_ch
);

   logic [CFG_W-1:0]         line_height;
   logic [CFG_W-1:0]         baseline_height;
   logic                     go;
   ktlm_stage_type           stage;
   logic [ADV_W-1:0]         adv_rd;
   logic signed [KERN_W-1:0] kern_rd;

   ktlm_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_ch          (csr_ch),
      .line_height     (line_height),
      .baseline_height (baseline_height)
   );

   ktlm_tables u_tables (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .go      (go),
      .stage   (stage),
      .adv_rd  (adv_rd),
      .kern_rd (kern_rd)
   );

   ktlm_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .adv_rd          (adv_rd),
      .kern_rd         (kern_rd),
      .line_height     (line_height),
      .baseline_height (baseline_height),
      .rsp_ch          (rsp_ch),
      .go              (go)
   );

endmodule

@@ src/ktlm_csr.sv @@
module ktlm_csr import ktlm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ktlm_csr_if.sink         csr_ch,
   output logic [CFG_W-1:0] line_height,
   output logic [CFG_W-1:0] baseline_height
);

   logic [CFG_W-1:0] line_height_ff, line_height_in;
   logic [CFG_W-1:0] baseline_ff, baseline_in;

   assign csr_ch.ready    = 1'b1;
   assign line_height     = line_height_ff;
   assign baseline_height = baseline_ff;

   always_comb begin
      line_height_in = line_height_ff;
      baseline_in    = baseline_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LINE_HEIGHT: line_height_in = csr_ch.data;
            CSR_BASELINE:    baseline_in    = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_height_ff <= '0;
         baseline_ff    <= '0;
      end else begin
         line_height_ff <= line_height_in;
         baseline_ff    <= baseline_in;
      end
   end

endmodule

@@ src/ktlm_tables.sv @@
`include "kerned_text_line_measure_defines.svh"

module ktlm_tables import ktlm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   ktlm_req_if.sink                 req_ch,
   input  logic                     go,
   output ktlm_stage_type           stage,
   output logic [ADV_W-1:0]         adv_rd,
   output logic signed [KERN_W-1:0] kern_rd
);

   logic [GLYPH_CODES-1:0]    glyph_valid_ff;
   logic [ADV_W-1:0]          adv_mem [GLYPH_CODES];
   logic signed [KERN_W-1:0]  kern_mem [2 ** KIDX_W];

   logic [ADV_W-1:0]          adv_rd_ff;
   logic signed [KERN_W-1:0]  kern_rd_ff;
   ktlm_stage_type            stage_ff, stage_in;
   logic [CODE_W-1:0]         prev_code_ff, prev_code_in;
   logic                      prev_had_ff, prev_had_in;
   logic                      clearing_ff, clearing_in;
   logic [KIDX_W-1:0]         clr_addr_ff, clr_addr_in;

   logic                      accept;
   logic                      in_range;
   logic                      has_glyph;
   logic                      is_newline;
   logic [GIDX_W-1:0]         gidx;
   logic                      kern_we;
   logic [KIDX_W-1:0]         kern_wa;
   logic signed [KERN_W-1:0]  kern_wd;

   assign req_ch.ready = !clearing_ff && go;
   assign accept       = req_ch.valid && req_ch.ready;
   assign gidx         = req_ch.char_code[GIDX_W-1:0];
   assign in_range     = int'(req_ch.char_code) < GLYPH_CODES;
   assign has_glyph    = in_range && glyph_valid_ff[gidx];
   assign is_newline   = req_ch.char_code == NEWLINE_CODE;
   assign stage        = stage_ff;
   assign adv_rd       = adv_rd_ff;
   assign kern_rd      = kern_rd_ff;

   always_comb begin
      stage_in     = stage_ff;
      prev_code_in = prev_code_ff;
      prev_had_in  = prev_had_ff;
      clearing_in  = clearing_ff;
      clr_addr_in  = clr_addr_ff;
      kern_we      = 1'b0;
      kern_wa      = {req_ch.char_code, req_ch.second_code};
      kern_wd      = req_ch.kern_amount;
      if (clearing_ff) begin
         kern_we     = 1'b1;
         kern_wa     = clr_addr_ff;
         kern_wd     = '0;
         clr_addr_in = clr_addr_ff + KIDX_W'(1);
         clearing_in = clr_addr_ff != {KIDX_W{1'b1}};
      end
      if (go) begin
         stage_in            = '0;
         stage_in.valid      = accept &&
                               (req_ch.action == ACT_CHAR || req_ch.action == ACT_END);
         stage_in.is_end     = req_ch.action == ACT_END;
         stage_in.is_newline = is_newline;
         stage_in.has_glyph  = has_glyph;
         stage_in.prev_had   = prev_had_ff;
      end
      if (accept) begin
         case (req_ch.action)
            ACT_KERN: begin
               kern_we = 1'b1;
            end
            ACT_CHAR: begin
               prev_code_in = req_ch.char_code;
               prev_had_in  = has_glyph && !is_newline;
            end
            ACT_END: begin
               prev_code_in = '0;
               prev_had_in  = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_valid_ff <= '0;
         stage_ff       <= '0;
         prev_code_ff   <= '0;
         prev_had_ff    <= 1'b0;
         clearing_ff    <= 1'b1;
         clr_addr_ff    <= '0;
      end else begin
         if (accept && req_ch.action == ACT_GLYPH && in_range) begin
            glyph_valid_ff[gidx] <= req_ch.glyph_present;
         end
         stage_ff     <= stage_in;
         prev_code_ff <= prev_code_in;
         prev_had_ff  <= prev_had_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.action == ACT_GLYPH && in_range) begin
         adv_mem[gidx] <= req_ch.advance;
      end
      if (accept) begin
         adv_rd_ff <= adv_mem[gidx];
      end
   end

   always_ff @(posedge clock) begin
      if (kern_we) begin
         kern_mem[kern_wa] <= kern_wd;
      end
      if (accept) begin
         kern_rd_ff <= kern_mem[{prev_code_ff, req_ch.char_code}];
      end
   end

   `KTLM_ASSERT_NOW(a_no_accept_clearing, clock, reset, clearing_ff, !accept)
   `KTLM_ASSERT_NEXT(a_newline_drops_prev, clock, reset,
      accept && req_ch.action == ACT_CHAR && is_newline, !prev_had_ff)
   `KTLM_ASSERT_NEXT(a_stage_holds, clock, reset, !go, $stable(stage_ff))

endmodule

@@ src/ktlm_accum.sv @@
`include "kerned_text_line_measure_defines.svh"

module ktlm_accum import ktlm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  ktlm_stage_type           stage,
   input  logic [ADV_W-1:0]         adv_rd,
   input  logic signed [KERN_W-1:0] kern_rd,
   input  logic [CFG_W-1:0]         line_height,
   input  logic [CFG_W-1:0]         baseline_height,
   ktlm_rsp_if.source               rsp_ch,
   output logic                     go
);

   logic signed [WIDTH_W-1:0] acc_ff, acc_in;
   logic [WIDEST_W-1:0]       widest_ff, widest_in;
   logic [INDEX_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [WIDTH_W-1:0] rsp_width_ff, rsp_width_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [WIDEST_W-1:0]       rsp_widest_ff, rsp_widest_in;
   logic [HEIGHT_W-1:0]       rsp_height_ff, rsp_height_in;
   logic                      rsp_final_ff, rsp_final_in;

   logic                      emits;
   logic                      work;
   logic signed [WIDTH_W-1:0] acc_kern;
   logic signed [WIDTH_W-1:0] acc_adv;
   logic [WIDEST_W-1:0]       widest_new;
   logic [HEIGHT_W-1:0]       height_val;

   assign emits = stage.valid && (stage.is_end || stage.is_newline);
   assign go    = !emits || !rsp_valid_ff || rsp_ch.ready;
   assign work  = go && stage.valid;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.line_width  = rsp_width_ff;
   assign rsp_ch.line_index  = rsp_index_ff;
   assign rsp_ch.text_width  = rsp_widest_ff;
   assign rsp_ch.text_height = rsp_height_ff;
   assign rsp_ch.is_final    = rsp_final_ff;

   always_comb begin
      acc_kern = acc_ff;
      if (stage.prev_had) begin
         acc_kern = sat_width((WIDTH_W+2)'(acc_ff) + (WIDTH_W+2)'(kern_rd));
      end
      acc_adv = acc_kern;
      if (stage.has_glyph) begin
         acc_adv = sat_width((WIDTH_W+2)'(acc_kern) +
                             $signed({{(WIDTH_W+2-ADV_W){1'b0}}, adv_rd}));
      end
      widest_new = widest_ff;
      if (!acc_ff[WIDTH_W-1] && acc_ff[WIDEST_W-1:0] > widest_ff) begin
         widest_new = acc_ff[WIDEST_W-1:0];
      end
      height_val = HEIGHT_W'(count_ff) * HEIGHT_W'(line_height) +
                   HEIGHT_W'(baseline_height);
   end

   always_comb begin
      acc_in        = acc_ff;
      widest_in     = widest_ff;
      count_in      = count_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_widest_in = rsp_widest_ff;
      rsp_height_in = rsp_height_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (work) begin
         if (emits) begin
            rsp_valid_in  = 1'b1;
            rsp_width_in  = acc_ff;
            rsp_index_in  = count_ff;
            rsp_widest_in = widest_new;
            rsp_height_in = height_val;
            rsp_final_in  = stage.is_end;
            acc_in        = '0;
            if (stage.is_end) begin
               widest_in = '0;
               count_in  = '0;
            end else begin
               widest_in = widest_new;
               if (count_ff != LINE_LAST) begin
                  count_in = count_ff + INDEX_W'(1);
               end
            end
         end else begin
            acc_in = acc_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         widest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         widest_ff    <= widest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_width_ff  <= rsp_width_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_widest_ff <= rsp_widest_in;
      rsp_height_ff <= rsp_height_in;
      rsp_final_ff  <= rsp_final_in;
   end

   `KTLM_ASSERT_NEXT(a_end_clears_text, clock, reset, work && stage.is_end,
      count_ff == '0 && acc_ff == '0 && widest_ff == '0)
   `KTLM_ASSERT_NEXT(a_widest_grows, clock, reset, work && !stage.is_end,
      widest_ff >= $past(widest_ff))
   `KTLM_ASSERT_NOW(a_stall_needs_word, clock, reset, !go, rsp_valid_ff && emits)

endmodule

@@ tb/kerned_text_line_measure_tb.sv @@
module kerned_text_line_measure_tb;
   import ktlm_pkg::*;

   typedef struct packed {
      ktlm_action_type          action;
      logic [CODE_W-1:0]        char_code;
      logic [CODE_W-1:0]        second_code;
      logic                     glyph_present;
      logic [ADV_W-1:0]         advance;
      logic signed [KERN_W-1:0] kern_amount;
   } req_word_type;

   typedef struct packed {
      logic signed [WIDTH_W-1:0] line_width;
      logic [INDEX_W-1:0]        line_index;
      logic [WIDEST_W-1:0]       text_width;
      logic [HEIGHT_W-1:0]       text_height;
      logic                      is_final;
   } line_result_type;

   typedef struct {
      req_word_type    word;
      bit              typed;
      line_result_type want;
   } dir_row_type;

   localparam line_result_type EMPTY_TEXT = '{line_width: '0, line_index: '0, text_width: '0,
                                              text_height: '0, is_final: 1'b1};
   localparam line_result_type EMPTY_LINE = '{line_width: '0, line_index: '0, text_width: '0,
                                              text_height: '0, is_final: 1'b0};
   localparam int WIDTH_TOP    = 1048575;
   localparam int WIDTH_BOTTOM = -1048576;

   logic clock;
   logic reset;

   ktlm_req_if req_ch();
   ktlm_rsp_if rsp_ch();
   ktlm_csr_if csr_ch();

   kerned_text_line_measure dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   bit                     glyph_ok [GLYPH_CODES];
   bit [ADV_W-1:0]         glyph_adv [GLYPH_CODES];
   bit signed [KERN_W-1:0] kern_tab [65536];
   int                     line_acc;
   int                     widest_px;
   int                     newline_total;
   bit [CODE_W-1:0]        prev_code;
   bit                     prev_glyph;
   int                     line_h;
   int                     base_h;

   line_result_type pending_lines [$];
   dir_row_type     directed_rows [$];
   bit              glyph_written [256];
   int              written_codes [$];
   int              idle_pct = 37;
   int              fail_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #36000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int clamp_width(input int v);
      if (v > WIDTH_TOP) return WIDTH_TOP;
      if (v < WIDTH_BOTTOM) return WIDTH_BOTTOM;
      return v;
   endfunction

   function automatic void close_line(output line_result_type r, input bit fin);
      if (line_acc > 0 && line_acc > widest_px) widest_px = line_acc;
      r.line_width  = WIDTH_W'(line_acc);
      r.line_index  = INDEX_W'(newline_total);
      r.text_width  = WIDEST_W'(widest_px);
      r.text_height = HEIGHT_W'(newline_total * line_h + base_h);
      r.is_final    = fin;
   endfunction

   // returns 1 when the word produces a line result
   function automatic bit measure_word(input req_word_type w, output line_result_type r);
      bit has;
      r = '0;
      case (w.action)
         ACT_GLYPH: begin
            if (int'(w.char_code) < GLYPH_CODES) begin
               glyph_adv[w.char_code] = w.advance;
               glyph_ok[w.char_code]  = w.glyph_present;
            end
            return 1'b0;
         end
         ACT_KERN: begin
            kern_tab[{w.char_code, w.second_code}] = w.kern_amount;
            return 1'b0;
         end
         ACT_CHAR: begin
            if (w.char_code == NEWLINE_CODE) begin
               close_line(r, 1'b0);
               line_acc = 0;
               if (newline_total < MAX_LINES - 1) newline_total++;
               prev_code  = w.char_code;
               prev_glyph = 1'b0;
               return 1'b1;
            end
            if (prev_glyph)
               line_acc = clamp_width(line_acc + int'(kern_tab[{prev_code, w.char_code}]));
            has = int'(w.char_code) < GLYPH_CODES && glyph_ok[w.char_code];
            if (has) line_acc = clamp_width(line_acc + int'(glyph_adv[w.char_code]));
            prev_code  = w.char_code;
            prev_glyph = has;
            return 1'b0;
         end
         default: begin
            close_line(r, 1'b1);
            line_acc      = 0;
            widest_px     = 0;
            newline_total = 0;
            prev_code     = '0;
            prev_glyph    = 1'b0;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic req_word_type word_of(input ktlm_action_type a, input int code,
                                            input int second, input bit present,
                                            input int adv, input int kern);
      req_word_type w;
      w.action        = a;
      w.char_code     = CODE_W'(code);
      w.second_code   = CODE_W'(second);
      w.glyph_present = present;
      w.advance       = ADV_W'(adv);
      w.kern_amount   = KERN_W'(kern);
      return w;
   endfunction

   function automatic void add_row(input req_word_type w, input bit typed,
                                   input line_result_type want);
      dir_row_type row;
      row.word  = w;
      row.typed = typed;
      row.want  = want;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input req_word_type w, input bit typed = 1'b0,
                            input line_result_type want = '0);
      line_result_type r;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= w.action;
      req_ch.char_code     <= w.char_code;
      req_ch.second_code   <= w.second_code;
      req_ch.glyph_present <= w.glyph_present;
      req_ch.advance       <= w.advance;
      req_ch.kern_amount   <= w.kern_amount;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (w.action == ACT_GLYPH && !glyph_written[w.char_code]) begin
         glyph_written[w.char_code] = 1'b1;
         written_codes.insert(written_codes.size(), int'(w.char_code));
      end
      if (measure_word(w, r)) pending_lines.insert(pending_lines.size(), typed ? want : r);
      @(negedge clock);
   endtask

   task automatic wait_lines_done();
      req_ch.valid <= 1'b0;
      while (pending_lines.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input ktlm_csr_type idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CFG_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == CSR_LINE_HEIGHT) line_h = value;
      else base_h = value;
      @(negedge clock);
   endtask

   task automatic set_config(input int lh, input int bl);
      wait_lines_done();
      write_csr(CSR_LINE_HEIGHT, lh);
      write_csr(CSR_BASELINE, bl);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic int pick_written();
      return written_codes[$urandom_range(0, written_codes.size() - 1)];
   endfunction

   task automatic random_text(input int count);
      req_word_type w;
      int           pick;
      repeat (count) begin
         w.char_code     = CODE_W'($urandom);
         w.second_code   = CODE_W'($urandom);
         w.glyph_present = 1'($urandom);
         w.advance       = ADV_W'($urandom);
         w.kern_amount   = KERN_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            w.action        = ACT_GLYPH;
            w.glyph_present = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) w.advance = ADV_W'($urandom_range(0, 40));
         end else if (pick < 16) begin
            w.action = ACT_KERN;
            if ($urandom_range(0, 4) != 0) begin
               w.char_code   = CODE_W'(pick_written());
               w.second_code = CODE_W'(pick_written());
            end
         end else if (pick < 90) begin
            w.action = ACT_CHAR;
            if ($urandom_range(0, 99) < 15) w.char_code = NEWLINE_CODE;
            else w.char_code = CODE_W'(pick_written());
         end else begin
            w.action = ACT_END;
         end
         send_word(w);
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   task automatic cmp_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_lines.size() == 0) begin
            $display("%0t: unexpected word, expected none, got width %0d index %0d final %0d",
                     $time, rsp_ch.line_width, rsp_ch.line_index, rsp_ch.is_final);
            fail_count++;
         end else begin
            want = pending_lines.pop_front();
            cmp_field("line_width", $signed(want.line_width), rsp_ch.line_width);
            cmp_field("line_index", want.line_index, rsp_ch.line_index);
            cmp_field("text_width", want.text_width, rsp_ch.text_width);
            cmp_field("text_height", want.text_height, rsp_ch.text_height);
            cmp_field("is_final", want.is_final, rsp_ch.is_final);
         end
      end
   end

   initial begin
      line_acc      = 0;
      widest_px     = 0;
      newline_total = 0;
      prev_code     = '0;
      prev_glyph    = 1'b0;
      line_h        = 0;
      base_h        = 0;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.action        <= ACT_GLYPH;
      req_ch.char_code     <= '0;
      req_ch.second_code   <= '0;
      req_ch.glyph_present <= 1'b0;
      req_ch.advance       <= '0;
      req_ch.kern_amount   <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= CSR_LINE_HEIGHT;
      csr_ch.data          <= '0;

      add_row(word_of(ACT_END, 0, 0, 0, 0, 0), 1'b1, EMPTY_TEXT);
      add_row(word_of(ACT_GLYPH, 0, 0, 1, 4095, 0), 1'b0, '0);
      add_row(word_of(ACT_GLYPH, 255, 0, 1, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_GLYPH, 10, 0, 1, 100, 0), 1'b0, '0);
      add_row(word_of(ACT_GLYPH, 65, 0, 1, 7, 0), 1'b0, '0);
      add_row(word_of(ACT_GLYPH, 66, 0, 0, 2048, 0), 1'b0, '0);
      add_row(word_of(ACT_KERN, 65, 65, 0, 0, -128), 1'b0, '0);
      add_row(word_of(ACT_KERN, 0, 255, 0, 0, 127), 1'b0, '0);
      add_row(word_of(ACT_KERN, 255, 0, 0, 0, -1), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 65, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 65, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 66, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 65, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 10, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 255, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 10, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 255, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_END, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_END, 0, 0, 0, 0, 0), 1'b1, EMPTY_TEXT);
      add_row(word_of(ACT_KERN, 10, 65, 0, 0, 5), 1'b0, '0);
      add_row(word_of(ACT_CHAR, 10, 0, 0, 0, 0), 1'b1, EMPTY_LINE);
      add_row(word_of(ACT_CHAR, 65, 0, 0, 0, 0), 1'b0, '0);
      add_row(word_of(ACT_END, 0, 0, 0, 0, 0), 1'b0, '0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      set_config(4095, 4095);
      random_text(32);
      set_config(0, 4095);
      random_text(32);
      set_config(4095, 0);
      random_text(32);
      set_config($urandom_range(0, 4095), $urandom_range(0, 4095));
      random_text(32);
      set_config($urandom_range(0, 63), $urandom_range(0, 4095));
      random_text(32);

      // positive saturation, no idling on either side
      set_config($urandom_range(0, 4095), $urandom_range(0, 4095));
      idle_pct = 0;
      send_word(word_of(ACT_GLYPH, 1, 0, 1, 4095, 0));
      send_word(word_of(ACT_KERN, 1, 1, 0, 0, 127));
      repeat (250) send_word(word_of(ACT_CHAR, 1, 0, 0, 0, 0));
      send_word(word_of(ACT_CHAR, 10, 0, 0, 0, 0));
      send_word(word_of(ACT_CHAR, 1, 0, 0, 0, 0));
      send_word(word_of(ACT_END, 0, 0, 0, 0, 0));
      idle_pct = 37;
      random_text(20);

      wait_lines_done();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
